// ===== rtl/ebus_telegram_field_parser_assert.svh =====
// Assertion helpers shared by the parser top level.
// Both expect signals named clk and rst in the using scope.
`ifndef EBUS_TELEGRAM_FIELD_PARSER_ASSERT_SVH
`define EBUS_TELEGRAM_FIELD_PARSER_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define ETFP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ETFP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/etfp_pkg.sv =====
package etfp_pkg;

  localparam logic [7:0] SYN_BYTE = 8'hAA;
  localparam logic [7:0] ESC_BYTE = 8'hA9;
  localparam logic [7:0] ESC_CODE_ESC = 8'h00;
  localparam logic [7:0] ESC_CODE_SYN = 8'h01;
  localparam logic [7:0] ACK_BYTE = 8'h00;
  localparam logic [7:0] NAK_BYTE = 8'hFF;

  localparam logic [7:0] FILTER_DEST_RESET = 8'h26;
  localparam logic       FILTER_EN_RESET   = 1'b1;

  // Register index, taken from paddr[2]
  localparam logic REG_FILTER_DEST = 1'b0;
  localparam logic REG_FILTER_EN   = 1'b1;

  // Field kinds reported on the output
  localparam logic [3:0] KIND_SRC       = 4'd0;
  localparam logic [3:0] KIND_DST       = 4'd1;
  localparam logic [3:0] KIND_CMD_HI    = 4'd2;
  localparam logic [3:0] KIND_CMD_LO    = 4'd3;
  localparam logic [3:0] KIND_MLEN      = 4'd4;
  localparam logic [3:0] KIND_MDATA     = 4'd5;
  localparam logic [3:0] KIND_MCRC      = 4'd6;
  localparam logic [3:0] KIND_SACK      = 4'd7;
  localparam logic [3:0] KIND_SLEN      = 4'd8;
  localparam logic [3:0] KIND_SDATA     = 4'd9;
  localparam logic [3:0] KIND_SCRC      = 4'd10;
  localparam logic [3:0] KIND_MACK      = 4'd11;
  localparam logic [3:0] KIND_EXTRA     = 4'd12;
  localparam logic [3:0] KIND_TEL_END   = 4'd13;
  localparam logic [3:0] KIND_IDLE_SYNC = 4'd14;

  localparam logic [1:0] ACK_CLASS_ACK   = 2'd0;
  localparam logic [1:0] ACK_CLASS_NAK   = 2'd1;
  localparam logic [1:0] ACK_CLASS_OTHER = 2'd2;

  // Classified byte passed from front to back
  typedef struct packed {
    logic       is_sync;
    logic [7:0] value;
  } etfp_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } etfp_q_status_t;

  typedef struct packed {
    logic [3:0]  field_kind;
    logic [7:0]  field_value;
    logic [1:0]  ack_class;
    logic [7:0]  source_address;
    logic [7:0]  destination_address;
    logic [15:0] command_word;
    logic        telegram_match;
  } etfp_result_t;

endpackage

// ===== rtl/etfp_if.sv =====
interface etfp_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] received_byte;

  modport source (output valid, output received_byte, input ready);
  modport sink (input valid, input received_byte, output ready);
endinterface

interface etfp_field_if;
  logic        valid;
  logic        ready;
  logic [3:0]  field_kind;
  logic [7:0]  field_value;
  logic [1:0]  ack_class;
  logic [7:0]  source_address;
  logic [7:0]  destination_address;
  logic [15:0] command_word;
  logic        telegram_match;

  modport source (
    output valid, output field_kind, output field_value, output ack_class,
    output source_address, output destination_address, output command_word,
    output telegram_match, input ready
  );
  modport sink (
    input valid, input field_kind, input field_value, input ack_class,
    input source_address, input destination_address, input command_word,
    input telegram_match, output ready
  );
endinterface

// ===== rtl/ebus_telegram_field_parser.sv =====
// A byte accepted on in_ch is written into the queue, then popped into the output register that drives out_ch.
// Throughput: one byte per cycle while out_ch takes results, held by the two-entry queue and the output register.
// An escape byte (0xA9) is accepted and yields no result.
// Reset (rst, synchronous): field position to source address, escape flag,
// counter and held address/command cleared, queue emptied, filter back to 0x26, enabled.
`include "ebus_telegram_field_parser_assert.svh"

module ebus_telegram_field_parser #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  etfp_byte_if.sink   in_ch,
  etfp_field_if.source out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import etfp_pkg::*;

  logic [7:0]     filter_dest_reg;
  logic           filter_enable;
  logic           cfg_write;
  logic           push;
  logic           pop;
  etfp_item_t     push_item;
  etfp_item_t     pop_item;
  etfp_q_status_t q_status;
  etfp_result_t   result;
  logic           result_valid;

  // Configuration port
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      filter_dest_reg <= FILTER_DEST_RESET;
      filter_enable   <= FILTER_EN_RESET;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_FILTER_DEST: filter_dest_reg <= pwdata[7:0];
        REG_FILTER_EN:   filter_enable   <= pwdata[0];
        default:         filter_enable   <= filter_enable;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_FILTER_DEST: prdata = {24'd0, filter_dest_reg};
      REG_FILTER_EN:   prdata = {31'd0, filter_enable};
      default:         prdata = '0;
    endcase
  end

  etfp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_byte   (in_ch.received_byte),
    .in_ready  (in_ch.ready),
    .q_status  (q_status),
    .push      (push),
    .push_item (push_item)
  );

  etfp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .status    (q_status)
  );

  etfp_back u_back (
    .clk                (clk),
    .rst                (rst),
    .q_valid            (!q_status.empty),
    .q_item             (pop_item),
    .pop                (pop),
    .filter_destination (filter_dest_reg),
    .filter_enable      (filter_enable),
    .out_valid          (result_valid),
    .out_ready          (out_ch.ready),
    .out_result         (result)
  );

  assign out_ch.valid               = result_valid;
  assign out_ch.field_kind          = result.field_kind;
  assign out_ch.field_value         = result.field_value;
  assign out_ch.ack_class           = result.ack_class;
  assign out_ch.source_address      = result.source_address;
  assign out_ch.destination_address = result.destination_address;
  assign out_ch.command_word        = result.command_word;
  assign out_ch.telegram_match      = result.telegram_match;

  // Telegram summary fields only on a closing SYN
  `ETFP_ASSERT_NOW(a_summary_only_on_end,
    out_ch.valid && out_ch.field_kind != KIND_TEL_END,
    out_ch.source_address == 8'd0 && out_ch.destination_address == 8'd0 &&
    out_ch.command_word == 16'd0 && !out_ch.telegram_match,
    "summary fields set outside telegram end")

  `ETFP_ASSERT_NOW(a_sync_value,
    out_ch.valid && (out_ch.field_kind == KIND_TEL_END ||
                     out_ch.field_kind == KIND_IDLE_SYNC),
    out_ch.field_value == SYN_BYTE,
    "sync result without SYN value")

  `ETFP_ASSERT_NOW(a_ack_class_kinds,
    out_ch.valid && out_ch.field_kind != KIND_SACK && out_ch.field_kind != KIND_MACK,
    out_ch.ack_class == ACK_CLASS_ACK,
    "ack class set on a non-ack field")

  // An accepted escape byte never reaches the queue
  `ETFP_ASSERT_NEXT(a_escape_no_push,
    in_ch.valid && in_ch.ready && in_ch.received_byte == ESC_BYTE &&
    q_status.empty && !push,
    q_status.empty,
    "escape byte entered the queue")

endmodule

// ===== rtl/etfp_front.sv =====
module etfp_front (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  input  logic [7:0]              in_byte,
  output logic                    in_ready,
  input  etfp_pkg::etfp_q_status_t q_status,
  output logic                    push,
  output etfp_pkg::etfp_item_t    push_item
);
  import etfp_pkg::*;

  logic escape_pending;
  logic escape_pending_next;
  logic accept;
  logic is_syn;
  logic is_esc;

  assign in_ready = !q_status.full;
  assign accept   = in_valid && in_ready;
  assign is_syn   = (in_byte == SYN_BYTE);
  assign is_esc   = (in_byte == ESC_BYTE);

  // Escape prefix produces nothing; everything else goes to the queue
  assign push = accept && !is_esc;

  always_comb begin
    push_item.is_sync = is_syn;
    push_item.value   = in_byte;
    if (is_syn) begin
      push_item.value = SYN_BYTE;
    end else if (escape_pending && in_byte == ESC_CODE_ESC) begin
      push_item.value = ESC_BYTE;
    end else if (escape_pending && in_byte == ESC_CODE_SYN) begin
      push_item.value = SYN_BYTE;
    end
  end

  // A SYN leaves a pending escape in place for the next data byte
  always_comb begin
    escape_pending_next = escape_pending;
    if (accept) begin
      if (is_esc) begin
        escape_pending_next = 1'b1;
      end else if (!is_syn) begin
        escape_pending_next = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      escape_pending <= 1'b0;
    end else begin
      escape_pending <= escape_pending_next;
    end
  end

endmodule

// ===== rtl/etfp_queue.sv =====
// Small FIFO between front and back; DEPTH must be 2 or more.
module etfp_queue #(
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     push,
  input  etfp_pkg::etfp_item_t     push_item,
  input  logic                     pop,
  output etfp_pkg::etfp_item_t     pop_item,
  output etfp_pkg::etfp_q_status_t status
);
  import etfp_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  etfp_item_t       entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign status.full  = (count == FULL_CNT);
  assign status.empty = (count == '0);
  assign pop_item     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/etfp_back.sv =====
module etfp_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  etfp_pkg::etfp_item_t   q_item,
  output logic                   pop,
  input  logic [7:0]             filter_destination,
  input  logic                   filter_enable,
  output logic                   out_valid,
  input  logic                   out_ready,
  output etfp_pkg::etfp_result_t out_result
);
  import etfp_pkg::*;

  typedef enum logic [3:0] {
    POS_SRC    = 4'd0,
    POS_DST    = 4'd1,
    POS_CMD_HI = 4'd2,
    POS_CMD_LO = 4'd3,
    POS_MLEN   = 4'd4,
    POS_MDATA  = 4'd5,
    POS_MCRC   = 4'd6,
    POS_SACK   = 4'd7,
    POS_SLEN   = 4'd8,
    POS_SDATA  = 4'd9,
    POS_SCRC   = 4'd10,
    POS_MACK   = 4'd11,
    POS_EXTRA  = 4'd12
  } pos_t;

  pos_t         pos;
  pos_t         pos_next;
  logic [7:0]   bytes_remaining;
  logic [7:0]   bytes_remaining_next;
  logic [7:0]   held_source;
  logic [7:0]   held_source_next;
  logic [7:0]   held_destination;
  logic [7:0]   held_destination_next;
  logic [15:0]  held_command;
  logic [15:0]  held_command_next;
  etfp_result_t result_next;
  logic [7:0]   b;
  logic [7:0]   count_dec;

  // Load the output register whenever it is empty or being drained
  assign pop       = q_valid && (!out_valid || out_ready);
  assign b         = q_item.value;
  assign count_dec = bytes_remaining - 8'd1;

  always_comb begin
    pos_next              = pos;
    bytes_remaining_next  = bytes_remaining;
    held_source_next      = held_source;
    held_destination_next = held_destination;
    held_command_next     = held_command;
    result_next           = '0;
    result_next.field_value = b;

    if (q_item.is_sync) begin
      result_next.field_value = SYN_BYTE;
      if (pos != POS_SRC) begin
        result_next.field_kind          = KIND_TEL_END;
        result_next.source_address      = held_source;
        result_next.destination_address = held_destination;
        result_next.command_word        = held_command;
        result_next.telegram_match      = !filter_enable ||
                                          (held_destination == filter_destination);
        pos_next = POS_SRC;
      end else begin
        result_next.field_kind = KIND_IDLE_SYNC;
      end
    end else begin
      result_next.field_kind = pos;
      unique case (pos) inside
        POS_SRC: begin
          held_source_next = b;
          pos_next         = POS_DST;
        end
        POS_DST: begin
          held_destination_next = b;
          pos_next              = POS_CMD_HI;
        end
        POS_CMD_HI: begin
          held_command_next = {8'd0, b};
          pos_next          = POS_CMD_LO;
        end
        POS_CMD_LO: begin
          held_command_next = {held_command[7:0], b};
          pos_next          = POS_MLEN;
        end
        POS_MLEN, POS_SLEN: begin
          // zero length skips straight to the CRC
          bytes_remaining_next = b;
          pos_next = pos_t'(pos + ((b != 8'd0) ? 4'd1 : 4'd2));
        end
        POS_MDATA, POS_SDATA: begin
          bytes_remaining_next = count_dec;
          if (count_dec == 8'd0) begin
            pos_next = pos_t'(pos + 4'd1);
          end
        end
        POS_MCRC, POS_SCRC: begin
          pos_next = pos_t'(pos + 4'd1);
        end
        POS_SACK, POS_MACK: begin
          if (b == ACK_BYTE) begin
            result_next.ack_class = ACK_CLASS_ACK;
          end else if (b == NAK_BYTE) begin
            result_next.ack_class = ACK_CLASS_NAK;
          end else begin
            result_next.ack_class = ACK_CLASS_OTHER;
          end
          pos_next = pos_t'(pos + 4'd1);
        end
        default: begin
          result_next.field_kind = KIND_EXTRA;
          pos_next               = POS_EXTRA;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos              <= POS_SRC;
      bytes_remaining  <= '0;
      held_source      <= '0;
      held_destination <= '0;
      held_command     <= '0;
      out_valid        <= 1'b0;
    end else begin
      if (pop) begin
        pos              <= pos_next;
        bytes_remaining  <= bytes_remaining_next;
        held_source      <= held_source_next;
        held_destination <= held_destination_next;
        held_command     <= held_command_next;
        out_valid        <= 1'b1;
        out_result       <= result_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== verif/ebus_telegram_field_parser_tb.sv =====
module ebus_telegram_field_parser_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import etfp_pkg::*;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  etfp_byte_if  rx_bytes ();
  etfp_field_if fields ();

  ebus_telegram_field_parser i_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (rx_bytes),
    .out_ch  (fields),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Field tagger state, mirrored from the bus bytes that were accepted
  logic [3:0]  field_pos;
  logic        esc_pending;
  logic [7:0]  data_left;
  logic [7:0]  held_src;
  logic [7:0]  held_dst;
  logic [15:0] held_cmd;
  logic [7:0]  filt_dst;
  logic        filt_en;

  etfp_result_t expected_fields [$];

  int send_idle_pct;
  int recv_idle_pct;
  int stall_left;
  int mismatches;
  int bytes_sent;
  int escapes_sent;
  int results_checked;
  int telegrams_closed;
  int telegrams_matched;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [7:0] rand_byte();
    logic [7:0] special [6] = '{SYN_BYTE, ESC_BYTE, 8'h00, 8'h01, 8'hFF, FILTER_DEST_RESET};
    if ($urandom_range(7) == 0) return special[3'($urandom_range(5))];
    return 8'($urandom_range(255));
  endfunction

  // Tag one raw bus byte and queue the field result it produces, if any.
  function automatic void tag_received_byte(input logic [7:0] raw);
    etfp_result_t r;
    logic [7:0]   b;
    r = '0;
    b = raw;
    if (raw == SYN_BYTE) begin
      r.field_value = SYN_BYTE;
      if (field_pos != KIND_SRC) begin
        r.field_kind          = KIND_TEL_END;
        r.source_address      = held_src;
        r.destination_address = held_dst;
        r.command_word        = held_cmd;
        r.telegram_match      = !filt_en || (held_dst == filt_dst);
        field_pos             = KIND_SRC;
        telegrams_closed++;
        if (r.telegram_match) telegrams_matched++;
      end else begin
        r.field_kind = KIND_IDLE_SYNC;
      end
      expected_fields.push_back(r);
      return;
    end
    // escape flag survives a SYN, so it is only consumed here
    if (raw == ESC_BYTE) begin
      esc_pending = 1'b1;
      return;
    end
    if (esc_pending) begin
      esc_pending = 1'b0;
      if (raw == ESC_CODE_ESC) b = ESC_BYTE;
      else if (raw == ESC_CODE_SYN) b = SYN_BYTE;
    end
    r.field_value = b;
    r.field_kind  = field_pos;
    case (field_pos)
      KIND_SRC: begin
        held_src  = b;
        field_pos = KIND_DST;
      end
      KIND_DST: begin
        held_dst  = b;
        field_pos = KIND_CMD_HI;
      end
      KIND_CMD_HI: begin
        held_cmd  = {8'h00, b};
        field_pos = KIND_CMD_LO;
      end
      KIND_CMD_LO: begin
        held_cmd  = {held_cmd[7:0], b};
        field_pos = KIND_MLEN;
      end
      KIND_MLEN, KIND_SLEN: begin
        // zero length skips straight to the CRC
        data_left = b;
        field_pos = field_pos + ((b != 8'h00) ? 4'd1 : 4'd2);
      end
      KIND_MDATA, KIND_SDATA: begin
        data_left = data_left - 8'd1;
        if (data_left == 8'h00) field_pos = field_pos + 4'd1;
      end
      KIND_MCRC, KIND_SCRC: begin
        field_pos = field_pos + 4'd1;
      end
      KIND_SACK, KIND_MACK: begin
        if (b == ACK_BYTE) r.ack_class = ACK_CLASS_ACK;
        else if (b == NAK_BYTE) r.ack_class = ACK_CLASS_NAK;
        else r.ack_class = ACK_CLASS_OTHER;
        field_pos = field_pos + 4'd1;
      end
      default: begin
        r.field_kind = KIND_EXTRA;
        field_pos    = KIND_EXTRA;
      end
    endcase
    expected_fields.push_back(r);
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("%0t ns: %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
  endtask

  task automatic check_field_result();
    etfp_result_t want;
    if (expected_fields.size() == 0) begin
      report_mismatch("field result with none pending", 16'(fields.field_kind), 16'h0);
      return;
    end
    want = expected_fields.pop_front();
    results_checked++;
    if (fields.field_kind !== want.field_kind)
      report_mismatch("field_kind", 16'(fields.field_kind), 16'(want.field_kind));
    if (fields.field_value !== want.field_value)
      report_mismatch("field_value", 16'(fields.field_value), 16'(want.field_value));
    if (fields.ack_class !== want.ack_class)
      report_mismatch("ack_class", 16'(fields.ack_class), 16'(want.ack_class));
    if (fields.source_address !== want.source_address)
      report_mismatch("source_address", 16'(fields.source_address),
                      16'(want.source_address));
    if (fields.destination_address !== want.destination_address)
      report_mismatch("destination_address", 16'(fields.destination_address),
                      16'(want.destination_address));
    if (fields.command_word !== want.command_word)
      report_mismatch("command_word", fields.command_word, want.command_word);
    if (fields.telegram_match !== want.telegram_match)
      report_mismatch("telegram_match", 16'(fields.telegram_match),
                      16'(want.telegram_match));
  endtask

  initial begin : result_monitor
    fields.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && fields.valid === 1'b1 && fields.ready === 1'b1) check_field_result();
      if (stall_left > 0) begin
        fields.ready <= 1'b0;
        stall_left--;
      end else begin
        fields.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one raw byte; valid stays high afterwards so back-to-back transfers need no gap.
  task automatic send_byte(input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      rx_bytes.valid <= 1'b0;
      @(posedge clk);
    end
    rx_bytes.valid         <= 1'b1;
    rx_bytes.received_byte <= b;
    do @(posedge clk); while (rx_bytes.ready !== 1'b1);
    tag_received_byte(b);
    if (b == ESC_BYTE) escapes_sent++;
    else bytes_sent++;
  endtask

  // Send a decoded byte in its escaped on-wire form.
  task automatic send_encoded(input logic [7:0] b);
    if (b == SYN_BYTE) begin
      send_byte(ESC_BYTE);
      send_byte(ESC_CODE_SYN);
    end else if (b == ESC_BYTE) begin
      send_byte(ESC_BYTE);
      send_byte(ESC_CODE_ESC);
    end else begin
      // a needless escape leaves other bytes unchanged
      if (b != ESC_CODE_ESC && b != ESC_CODE_SYN && $urandom_range(19) == 0)
        send_byte(ESC_BYTE);
      send_byte(b);
    end
  endtask

  task automatic send_random_telegram();
    logic [7:0] len;
    logic [7:0] ack;
    int         extra;
    send_encoded(rand_byte());
    send_encoded($urandom_range(1) ? filt_dst : rand_byte());
    send_encoded(rand_byte());
    send_encoded(rand_byte());
    // master part, then slave part: length, data, CRC, ACK of the other side
    repeat (2) begin
      if ($urandom_range(99) == 0) len = 8'($urandom_range(255, 100));
      else if ($urandom_range(3) == 0) len = 8'h00;
      else len = 8'($urandom_range(6, 1));
      send_encoded(len);
      repeat (len) send_encoded(rand_byte());
      send_encoded(rand_byte());
      case ($urandom_range(2))
        0: ack = ACK_BYTE;
        1: ack = NAK_BYTE;
        default: ack = rand_byte();
      endcase
      send_encoded(ack);
    end
    extra = ($urandom_range(3) == 0) ? $urandom_range(3, 1) : 0;
    repeat (extra) send_encoded(rand_byte());
    send_byte(SYN_BYTE);
  endtask

  // Drop valid and hold until every queued result has been seen, plus the pipeline depth.
  task automatic wait_for_results();
    rx_bytes.valid <= 1'b0;
    for (int i = 0; i < 50000 && expected_fields.size() != 0; i++) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx == REG_FILTER_DEST) filt_dst = value[7:0];
    else filt_en = value[0];
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_filter(input logic [7:0] dst, input logic en);
    wait_for_results();
    write_reg(REG_FILTER_DEST, {24'h0, dst});
    write_reg(REG_FILTER_EN, {31'h0, en});
  endtask

  // Idle sync, early close, escapes in the command, data and source fields, zero length, ACK and NAK,
  // trailing byte, escape ahead of a SYN and a repeated escape.
  task automatic test_directed_fields();
    logic [7:0] seq [25] = '{
      8'hAA, 8'h00, 8'hAA, 8'hFF, 8'h26, 8'hA9, 8'h00, 8'hA9, 8'h01, 8'h02,
      8'hA9, 8'h05, 8'h80, 8'h7E, 8'h00, 8'h00, 8'h33, 8'hFF, 8'h12, 8'hA9,
      8'hAA, 8'hA9, 8'hA9, 8'h01, 8'hAA};
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic test_filter_settings();
    logic [7:0] dsts [5] = '{8'h00, 8'hFF, FILTER_DEST_RESET, 8'h00, 8'hFF};
    logic       ens  [5] = '{1'b1, 1'b1, 1'b0, 1'b0, 1'b1};
    foreach (dsts[i]) begin
      set_filter(dsts[i], ens[i]);
      repeat (3) send_random_telegram();
    end
  endtask

  task automatic test_output_stall();
    stall_left = 150;
    repeat (2) send_random_telegram();
    wait_for_results();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_bytes);
    int target;
    int count;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    target        = bytes_sent + n_bytes;
    count         = 0;
    while (bytes_sent < target) begin
      count++;
      if (count % 20 == 0) begin
        case ($urandom_range(3))
          0: set_filter(8'h00, 1'($urandom_range(1)));
          1: set_filter(8'hFF, 1'($urandom_range(1)));
          default: set_filter(8'($urandom_range(255)), 1'($urandom_range(1)));
        endcase
      end
      if ($urandom_range(99) < 80) begin
        send_random_telegram();
      end else begin
        // noise and cut-off telegrams: raw bytes, then a SYN
        repeat ($urandom_range(12)) send_byte(rand_byte());
        send_byte(SYN_BYTE);
      end
    end
  endtask

  initial begin
    rst                    <= 1'b1;
    psel                   <= 1'b0;
    penable                <= 1'b0;
    pwrite                 <= 1'b0;
    paddr                  <= '0;
    pwdata                 <= '0;
    rx_bytes.valid         <= 1'b0;
    rx_bytes.received_byte <= '0;
    field_pos         = KIND_SRC;
    esc_pending       = 1'b0;
    data_left         = 8'h00;
    held_src          = 8'h00;
    held_dst          = 8'h00;
    held_cmd          = 16'h0000;
    filt_dst          = FILTER_DEST_RESET;
    filt_en           = FILTER_EN_RESET;
    send_idle_pct     = 29;
    recv_idle_pct     = 79;
    stall_left        = 0;
    mismatches        = 0;
    bytes_sent        = 0;
    escapes_sent      = 0;
    results_checked   = 0;
    telegrams_closed  = 0;
    telegrams_matched = 0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    test_directed_fields();
    test_filter_settings();
    test_output_stall();
    test_random_traffic(29, 79, 130);
    test_random_traffic(79, 29, 130);
    test_random_traffic(0, 0, 130);

    wait_for_results();
    repeat (16) @(posedge clk);
    if (expected_fields.size() != 0)
      report_mismatch("field results never delivered", 16'(expected_fields.size()), 16'h0);

    $display("Covered %0d bus bytes plus %0d escape prefixes, %0d field results checked,",
             bytes_sent, escapes_sent, results_checked);
    $display("%0d telegrams closed by SYN, %0d of them passing the destination filter",
             telegrams_closed, telegrams_matched);
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
